// ----- sv/assert_macros.svh -----
// Assertion macros shared by the nearest point search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property checked on every clock edge outside reset.
`define NPS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Same-cycle implication.
`define NPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");
// Next-cycle implication.
`define NPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define NPS_ASSERT(lbl, clk, rst, prop)
`define NPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NPS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/nps_pkg.sv -----
// Shared constants and controller/datapath interface types for nearest point search.
`timescale 1ns / 1ps
`default_nettype none
package nps_pkg;

  // Field widths of the stream items
  localparam int FIELD_W    = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int NODE_IDX_W = 8;
  localparam int DIST_OUT_W = 34;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEW_GROUP = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;     // capture the input item
    logic exec;      // run insert / clear / query setup
    logic scan;      // issue one table read
    logic finish;    // form the query result
    logic load_out;  // move result into the output register
  } nps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cmd_query;  // latched command is a query
    logic empty;      // no points stored
    logic scan_last;  // current read address is the last stored point
    logic pipe_busy;  // distance pipeline still holds a point
  } nps_stat_t;

endpackage
`default_nettype wire

// ----- sv/nps_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module nps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when we is set, read registered (old word on a write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- sv/nps_ctrl.sv -----
// Controller state machine for nearest point search.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  nps_pkg::nps_stat_t stat,
  output nps_pkg::nps_cmd_t  cmd
);
  import nps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;

  // Commands decoded from state
  always_comb begin
    cmd          = '0;
    s_tready     = (state == S_IDLE);
    cmd.latch    = (state == S_IDLE) && s_tvalid;
    cmd.exec     = (state == S_EXEC);
    cmd.scan     = (state == S_SCAN);
    cmd.finish   = (state == S_DRAIN) && !stat.pipe_busy;
    cmd.load_out = (state == S_DONE) && (!m_tvalid || m_tready);
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (stat.cmd_query && !stat.empty) state <= S_SCAN;
          else state <= S_DONE;
        end
        S_SCAN: begin
          if (stat.scan_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `NPS_ASSERT_NXT(a_accept_exec, clk, rst, s_tvalid && s_tready, state == S_EXEC)
  `NPS_ASSERT_NXT(a_hold_result, clk, rst, state == S_DONE && m_tvalid && !m_tready,
                  state == S_DONE && m_tvalid)
  `NPS_ASSERT_NXT(a_scan_runs, clk, rst, state == S_SCAN && !stat.scan_last,
                  state == S_SCAN)

endmodule
`default_nettype wire

// ----- sv/nps_datapath.sv -----
// Datapath for nearest point search: point table, distance pipeline, best tracker.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nps_datapath #(
  parameter int NODE_CAP   = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nps_pkg::nps_cmd_t                    cmd,
  output nps_pkg::nps_stat_t                   stat,
  input  logic [nps_pkg::CMD_W-1:0]            in_cmd,
  input  logic [nps_pkg::FIELD_W-1:0]          in_x,
  input  logic [nps_pkg::FIELD_W-1:0]          in_y,
  input  logic [nps_pkg::FIELD_W-1:0]          in_z,
  input  logic [nps_pkg::FIELD_W-1:0]          in_range,
  output logic [nps_pkg::STATUS_W-1:0]         out_status,
  output logic [nps_pkg::NODE_IDX_W-1:0]       out_index,
  output logic [nps_pkg::DIST_OUT_W-1:0]       out_dist
);
  import nps_pkg::*;

  localparam int IDX_W  = (NODE_CAP > 1) ? $clog2(NODE_CAP) : 1;
  localparam int CNT_W  = $clog2(NODE_CAP + 1);
  localparam int CB     = COORD_BITS;
  localparam int AD_W   = CB + 1;
  localparam int SQ_W   = 2 * AD_W;
  localparam int DIST_W = SQ_W + 1;
  localparam int R2_W   = 2 * FIELD_W;
  localparam int CMP_W  = (DIST_W > R2_W) ? DIST_W : R2_W;
  localparam int PT_W   = 3 * CB;

  // Coordinates taken to COORD_BITS
  logic signed [CB-1:0] cx, cy, cz;
  if (CB <= FIELD_W) begin : g_trim
    assign cx = in_x[CB-1:0];
    assign cy = in_y[CB-1:0];
    assign cz = in_z[CB-1:0];
  end else begin : g_widen
    assign cx = {{(CB-FIELD_W){1'b0}}, in_x};
    assign cy = {{(CB-FIELD_W){1'b0}}, in_y};
    assign cz = {{(CB-FIELD_W){1'b0}}, in_z};
  end

  // Magnitude of a coordinate difference
  function automatic logic [AD_W-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic signed [AD_W-1:0] d;
    d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    abs_diff = d[AD_W-1] ? AD_W'(-d) : AD_W'(d);
  endfunction

  logic [CMD_W-1:0]   cmd_q;
  logic [CB-1:0]      px, py, pz;
  logic [FIELD_W-1:0] range_q;
  logic [R2_W-1:0]    range_sq;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   scan_addr;
  logic               full;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [PT_W-1:0]    ram_rdata;

  logic               v_rd, v_a, v_b, v_c;
  logic [IDX_W-1:0]   idx_rd, idx_a, idx_b, idx_c;
  logic [AD_W-1:0]    ad_x, ad_y, ad_z;
  logic [SQ_W-1:0]    sq_x, sq_y, sq_z;
  logic [DIST_W-1:0]  dist_c;

  logic               have;
  logic [DIST_W-1:0]  best;
  logic [IDX_W-1:0]   best_idx;

  logic [STATUS_W-1:0]   res_status;
  logic [NODE_IDX_W-1:0] res_index;
  logic [DIST_OUT_W-1:0] res_dist;

  assign full = (count == CNT_W'(NODE_CAP));

  // Point table
  assign ram_we   = cmd.exec && (cmd_q == CMD_INSERT) && !full;
  assign ram_addr = cmd.exec ? count[IDX_W-1:0] : scan_addr;

  nps_ram #(
    .WIDTH (PT_W),
    .DEPTH (NODE_CAP)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({pz, py, px}),
    .rdata (ram_rdata)
  );

  // Status back to the controller
  always_comb begin
    stat.cmd_query = (cmd_q == CMD_QUERY);
    stat.empty     = (count == '0);
    stat.scan_last = ((CNT_W'(scan_addr) + CNT_W'(1)) == count);
    stat.pipe_busy = v_rd || v_a || v_b || v_c;
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q   <= in_cmd;
      px      <= cx;
      py      <= cy;
      pz      <= cz;
      range_q <= in_range;
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec && cmd_q == CMD_INSERT && !full) begin
      count <= count + CNT_W'(1);
    end else if (cmd.exec && cmd_q == CMD_NEW_GROUP) begin
      count <= '0;
    end
  end

  // Scan address and pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_rd <= 1'b0;
      v_a  <= 1'b0;
      v_b  <= 1'b0;
      v_c  <= 1'b0;
    end else begin
      v_rd <= cmd.scan;
      v_a  <= v_rd;
      v_b  <= v_a;
      v_c  <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      scan_addr <= '0;
    end else if (cmd.scan) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
  end

  // Distance pipeline: differences, squares, sum
  always_ff @(posedge clk) begin
    idx_rd <= scan_addr;
    idx_a  <= idx_rd;
    idx_b  <= idx_a;
    idx_c  <= idx_b;
    ad_x   <= abs_diff(px, ram_rdata[CB-1:0]);
    ad_y   <= abs_diff(py, ram_rdata[2*CB-1:CB]);
    ad_z   <= abs_diff(pz, ram_rdata[3*CB-1:2*CB]);
    sq_x   <= ad_x * ad_x;
    sq_y   <= ad_y * ad_y;
    sq_z   <= ad_z * ad_z;
    dist_c <= DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
  end

  // Best point tracker, earliest wins on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.exec) begin
      have <= 1'b0;
    end else if (v_c && (!have || dist_c < best)) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v_c && (!have || dist_c < best)) begin
      best     <= dist_c;
      best_idx <= idx_c;
    end
  end

  // Squared range, ready well before the scan ends
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      range_sq <= range_q * range_q;
    end
  end

  // Result forming
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_index <= '0;
      res_dist  <= '0;
      case (cmd_q)
        CMD_INSERT: begin
          res_status <= full ? ST_FULL : ST_OK;
          if (!full) res_index <= NODE_IDX_W'(count);
        end
        CMD_QUERY: begin
          res_status <= ST_NOT_FOUND;
        end
        default: begin
          res_status <= ST_OK;
        end
      endcase
    end else if (cmd.finish) begin
      res_dist <= DIST_OUT_W'(best);
      if (CMP_W'(best) <= CMP_W'(range_sq)) begin
        res_status <= ST_OK;
        res_index  <= NODE_IDX_W'(best_idx);
      end else begin
        res_status <= ST_NOT_FOUND;
        res_index  <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_index  <= res_index;
      out_dist   <= res_dist;
    end
  end

  `NPS_ASSERT(a_count_cap, clk, rst, count <= CNT_W'(NODE_CAP))
  `NPS_ASSERT_IMP(a_scan_in_table, clk, rst, cmd.scan, CNT_W'(scan_addr) < count)
  `NPS_ASSERT_IMP(a_finish_drained, clk, rst, cmd.finish, !(v_rd || v_a || v_b || v_c))
  `NPS_ASSERT_NXT(a_scan_feeds_pipe, clk, rst, cmd.scan, v_rd)

endmodule
`default_nettype wire

// ----- sv/nearest_point_search_core.sv -----
// Top level of the nearest point search core: stream ports, controller and datapath.
//
//  channel  dir  group                       content
//  s_*      in   tvalid tready tdata tuser  command item: point or query target, range
//  m_*      out  tvalid tready tdata tuser  result item: status, index, squared distance
//
// Insert, new group and an empty-table query go from the accept through the
// execute and done states to m_tvalid; the core then returns to idle for the next item.
// A query over N stored points goes through the execute, scan and drain states
// before done: the scan reads the point table one entry per cycle
// through its single RAM port, then a four deep distance pipeline drains.
// A new item is accepted while a result waits; a held result stalls the core
// only once the next result is ready to load.
// Synchronous reset empties the table at once (fill count); no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module nearest_point_search_core #(
  parameter int NODE_CAP   = 256,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // coord_x[15:0], coord_y[31:16], coord_z[47:32], query_range[63:48]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // node_index[7:0], best_sq_distance[41:8], zero[47:42]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import nps_pkg::*;

  nps_cmd_t  cmd;
  nps_stat_t stat;

  logic [NODE_IDX_W-1:0] node_index;
  logic [DIST_OUT_W-1:0] best_sq_distance;

  nps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nps_datapath #(
    .NODE_CAP   (NODE_CAP),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (s_tuser),
    .in_x       (s_tdata[15:0]),
    .in_y       (s_tdata[31:16]),
    .in_z       (s_tdata[47:32]),
    .in_range   (s_tdata[63:48]),
    .out_status (m_tuser),
    .out_index  (node_index),
    .out_dist   (best_sq_distance)
  );

  // Result packing
  assign m_tdata = {6'd0, best_sq_distance, node_index};

endmodule
`default_nettype wire
